// ===== rtl/core/wbcf_pkg.sv =====
package wbcf_pkg;

    // Window size; ring depth and counter widths follow from it.
    localparam int WINDOW_MAX = 1024;
    localparam int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

    // Register and field widths fixed by the interface.
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAR_W     = 8;
    localparam int PASS_W     = 32;
    localparam int CMP_W      = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    // Front-to-back queue.
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam int NUM_LETTERS = 4;

    typedef enum logic [2:0] {
        CODE_OTHER,
        CODE_A,
        CODE_C,
        CODE_G,
        CODE_T
    } t_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH,
        REG_MIN_A,
        REG_MIN_C,
        REG_MIN_G,
        REG_MIN_T
    } t_reg_idx;

    localparam t_code LETTER_CODES [NUM_LETTERS] = '{CODE_A, CODE_C, CODE_G, CODE_T};

    localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_C = 8'h43;
    localparam logic [CHAR_W-1:0] ASCII_G = 8'h47;
    localparam logic [CHAR_W-1:0] ASCII_T = 8'h54;

    // One classified item, as handed from front to back.
    typedef struct packed {
        t_code code;      // letter entering the window
        t_code old_code;  // letter leaving the window (valid when evict)
        logic  evict;
        logic  full;
        logic  last;
    } t_item;

    function automatic t_code letter_code(input logic [CHAR_W-1:0] b);
        t_code c;
        case (b)
            ASCII_A: c = CODE_A;
            ASCII_C: c = CODE_C;
            ASCII_G: c = CODE_G;
            ASCII_T: c = CODE_T;
            default: c = CODE_OTHER;
        endcase
        return c;
    endfunction

    // Zero means one; anything past the ring depth is clipped to it.
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] wl);
        logic [LEN_W-1:0] r;
        if (wl == '0) begin
            r = LEN_W'(1);
        end else if (int'(wl) > WINDOW_MAX) begin
            r = LEN_W'(WINDOW_MAX);
        end else begin
            r = LEN_W'(wl);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/wbcf_front.sv =====
module wbcf_front import wbcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic              i_end_of_string,
    input  logic [Q_CW-1:0]   i_q_count,
    output t_item             o_item,
    output logic              o_item_valid
);

    logic [AW-1:0]    r_wp, n_wp;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic             r_s1_valid;
    t_code            r_s1_code;
    logic             r_s1_evict;
    logic             r_s1_full;
    logic             r_s1_last;
    t_code            r_rd_code;
    t_code            r_ring [WINDOW_MAX];

    logic             accept;
    logic             evict;
    logic             full;
    t_code            code;
    logic [LEN_W-1:0] wp_ext;
    logic [LEN_W-1:0] old_ext;
    logic [AW-1:0]    old_idx;

    // Room is reserved for the item held in stage 1 as well.
    assign o_ready = ((Q_CW+1)'(i_q_count) + (Q_CW+1)'(r_s1_valid)) < (Q_CW+1)'(Q_DEPTH);
    assign accept  = i_valid && o_ready;
    assign code    = letter_code(i_char_byte);

    always_comb begin
        evict  = (r_fill >= i_len);
        full   = evict || ((r_fill + LEN_W'(1)) >= i_len);
        wp_ext = LEN_W'(r_wp);
        if (wp_ext >= i_len) begin
            old_ext = wp_ext - i_len;
        end else begin
            old_ext = wp_ext + LEN_W'(WINDOW_MAX) - i_len;
        end
        old_idx = AW'(old_ext);
    end

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (i_clear) begin
            n_wp   = '0;
            n_fill = '0;
        end else if (accept) begin
            if (i_end_of_string) begin
                n_wp   = '0;
                n_fill = '0;
            end else begin
                n_wp = (r_wp == AW'(WINDOW_MAX - 1)) ? '0 : r_wp + AW'(1);
                if (!evict) begin
                    n_fill = r_fill + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_fill     <= n_fill;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_code  <= code;
            r_s1_evict <= evict;
            r_s1_full  <= full;
            r_s1_last  <= i_end_of_string;
        end
    end

    // Ring: read of the leaving entry happens before this item's write,
    // so a full-depth window sees the old letter at the same address.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wp] <= code;
            r_rd_code    <= r_ring[old_idx];
        end
    end

    assign o_item_valid   = r_s1_valid;
    assign o_item.code     = r_s1_code;
    assign o_item.old_code = r_rd_code;
    assign o_item.evict    = r_s1_evict;
    assign o_item.full     = r_s1_full;
    assign o_item.last     = r_s1_last;

endmodule

// ===== rtl/core/wbcf_queue.sv =====
module wbcf_queue import wbcf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_item           i_item,
    input  logic            i_pop,
    output t_item           o_item,
    output logic            o_valid,
    output logic [Q_CW-1:0] o_count
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

// ===== rtl/core/wbcf_back.sv =====
module wbcf_back import wbcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic [CFG_W-1:0]  i_min [NUM_LETTERS],
    input  t_item             i_item,
    input  logic              i_item_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_window_full,
    output logic              o_window_passes,
    output logic [PASS_W-1:0] o_pass_total,
    output logic              o_final_result
);

    logic [LEN_W-1:0]  r_cnt [NUM_LETTERS];
    logic [LEN_W-1:0]  n_cnt [NUM_LETTERS];
    logic [PASS_W-1:0] r_pass, n_pass;
    logic              r_out_valid;
    logic              r_full;
    logic              r_passes;
    logic              r_last;
    logic [NUM_LETTERS-1:0] meet;
    logic              passes;
    logic              inc;
    logic              dec;

    assign o_pop = i_item_valid && (!r_out_valid || i_ready);

    always_comb begin
        for (int k = 0; k < NUM_LETTERS; k++) begin
            inc = (i_item.code == LETTER_CODES[k]);
            dec = i_item.evict && (i_item.old_code == LETTER_CODES[k]) && (r_cnt[k] != '0);
            if (inc && !dec) begin
                n_cnt[k] = r_cnt[k] + LEN_W'(1);
            end else if (!inc && dec) begin
                n_cnt[k] = r_cnt[k] - LEN_W'(1);
            end else begin
                n_cnt[k] = r_cnt[k];
            end
            meet[k] = CMP_W'(n_cnt[k]) >= CMP_W'(i_min[k]);
        end
        passes = i_item.full && (&meet);
        n_pass = (passes && (r_pass != '1)) ? r_pass + PASS_W'(1) : r_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pass      <= '0;
            for (int k = 0; k < NUM_LETTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear || (o_pop && i_item.last)) begin
                r_pass <= '0;
                for (int k = 0; k < NUM_LETTERS; k++) begin
                    r_cnt[k] <= '0;
                end
            end else if (o_pop) begin
                r_pass <= n_pass;
                for (int k = 0; k < NUM_LETTERS; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end
        end
    end

    logic [PASS_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_full   <= i_item.full;
            r_passes <= passes;
            r_total  <= n_pass;
            r_last   <= i_item.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_window_full   = r_full;
    assign o_window_passes = r_passes;
    assign o_pass_total    = r_total;
    assign o_final_result  = r_last;

endmodule

// ===== rtl/core/window_base_count_filter_unit.sv =====
// Sliding-window letter count filter.
// Input channel (i_valid/o_ready): one character item per handshake, with an
// end-of-string flag. Output channel (o_valid/i_ready): exactly one result
// item per input item, in order: window full, window passes, running pass
// total (saturating) and a copy of the end-of-string flag.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 window
// length, 1..4 minimum A/C/G/T counts. Writing the window length restarts
// the current string. Write config only while no item is in flight.
// From the accepting edge to output valid, stage 1 with the ring read moves
// into the queue, then the count update loads the output register. Throughput:
// one item per cycle while neither side stalls, set by the ring (one write and
// one registered read per cycle) and the count/compare update.
// A 4-entry queue between the ring front end and the count back end lets
// either side stall; when the receiver holds i_ready low the queue fills and
// o_ready drops once five items wait (four in queue/stage 1, one in output).
// Reset: window length 1, minimums 0, counts, fill level and pass total
// cleared. The ring itself is not cleared; entries are only read back
// after being written within the same string.
module window_base_count_filter_unit import wbcf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CHAR_W-1:0]    i_char_byte,
    input  logic                 i_end_of_string,
    // result items
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_window_full,
    output logic                 o_window_passes,
    output logic [PASS_W-1:0]    o_pass_total,
    output logic                 o_final_result
);

    logic [CFG_W-1:0] r_window_length;
    logic [CFG_W-1:0] r_min [NUM_LETTERS];
    logic             cfg_we;
    logic             clear;
    logic [LEN_W-1:0] len;

    t_item            front_item;
    logic             front_valid;
    t_item            q_item;
    logic             q_valid;
    logic [Q_CW-1:0]  q_count;
    logic             pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    // Window length write starts a new string.
    assign clear       = cfg_we && (t_reg_idx'(i_cfg_index) == REG_WINDOW_LENGTH);
    assign len         = eff_len(r_window_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CFG_W'(1);
            for (int k = 0; k < NUM_LETTERS; k++) begin
                r_min[k] <= '0;
            end
        end else if (cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                REG_MIN_A:         r_min[0]        <= i_cfg_data;
                REG_MIN_C:         r_min[1]        <= i_cfg_data;
                REG_MIN_G:         r_min[2]        <= i_cfg_data;
                REG_MIN_T:         r_min[3]        <= i_cfg_data;
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // Front: classify letter, track fill/pointer, access the ring.
    wbcf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_len           (len),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_byte     (i_char_byte),
        .i_end_of_string (i_end_of_string),
        .i_q_count       (q_count),
        .o_item          (front_item),
        .o_item_valid    (front_valid)
    );

    // Stage 1 always drains into the queue; front ready guarantees room.
    wbcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    // Back: running counts, threshold test, pass total, output register.
    wbcf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_min           (r_min),
        .i_item          (q_item),
        .i_item_valid    (q_valid),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_window_full   (o_window_full),
        .o_window_passes (o_window_passes),
        .o_pass_total    (o_pass_total),
        .o_final_result  (o_final_result)
    );

endmodule

// ===== tb/window_base_count_filter_unit_tb.sv =====
module window_base_count_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wbcf_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS = 650;   // random budget, long window phase included
    localparam int QUIET_ITEMS  = 120;   // tail of the run with no idling at all
    localparam int LONG_PHASE   = 5;     // phase that runs a long window well past its fill
    localparam int LONG_WINDOW  = 256;
    localparam int HOLD_PHASE   = 9;     // phase with the long output hold
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_PRINT    = 30;    // mismatch lines printed before going quiet

    // Lowest register index with nothing behind it
    localparam int FIRST_UNUSED_REG = int'(REG_MIN_T) + 1;

    localparam logic [CHAR_W-1:0] BASES [NUM_LETTERS] = '{ASCII_A, ASCII_C, ASCII_G, ASCII_T};

    typedef struct packed {
        logic              full;
        logic              passes;
        logic [PASS_W-1:0] total;
        logic              last;
    } t_window_result;

    // Tracks the window contents and letter counts, and holds the result
    // each accepted character should produce.
    class window_tally;
        t_code             ring [WINDOW_MAX];
        logic [AW-1:0]     wr_ptr;
        int unsigned       fill;
        int unsigned       letter_count [NUM_LETTERS+1];
        logic [PASS_W-1:0] pass_cnt;
        logic [CFG_W-1:0]  win_len;
        logic [CFG_W-1:0]  min_count [NUM_LETTERS+1];

        t_window_result    due_results [$];
        int                errors;
        int                chars_seen;
        int                strings_closed;
        int                reg_writes;
        int                results_checked;
        int                windows_passed;

        function new();
            win_len = 1;
            foreach (min_count[k]) min_count[k] = '0;
            clear_string();
        endfunction

        function void clear_string();
            wr_ptr   = '0;
            fill     = 0;
            pass_cnt = '0;
            foreach (letter_count[k]) letter_count[k] = 0;
        endfunction

        function t_code classify(logic [CHAR_W-1:0] b);
            if (b == ASCII_A) return CODE_A;
            else if (b == ASCII_C) return CODE_C;
            else if (b == ASCII_G) return CODE_G;
            else if (b == ASCII_T) return CODE_T;
            return CODE_OTHER;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_WINDOW_LENGTH: begin
                    // a new length restarts the string
                    win_len = data;
                    clear_string();
                end
                REG_MIN_A: min_count[CODE_A] = data;
                REG_MIN_C: min_count[CODE_C] = data;
                REG_MIN_G: min_count[CODE_G] = data;
                REG_MIN_T: min_count[CODE_T] = data;
                default: ;
            endcase
        endfunction

        function void take_char(logic [CHAR_W-1:0] b, logic last);
            int unsigned    span;
            t_code          code;
            t_code          leaving;
            t_window_result r;

            if (win_len == '0) span = 1;
            else if (win_len > WINDOW_MAX) span = WINDOW_MAX;
            else span = win_len;

            code = classify(b);
            if (fill >= span) begin
                // oldest char drops out; span of WINDOW_MAX wraps onto wr_ptr itself
                leaving = ring[wr_ptr - AW'(span)];
                if (letter_count[leaving] > 0) letter_count[leaving]--;
            end else begin
                fill++;
            end
            ring[wr_ptr] = code;
            letter_count[code]++;
            wr_ptr++;

            r.full   = (fill >= span);
            r.passes = r.full;
            for (int k = 0; k < NUM_LETTERS; k++) begin
                if (letter_count[LETTER_CODES[k]] < min_count[LETTER_CODES[k]]) r.passes = 1'b0;
            end
            if (r.passes && pass_cnt != '1) pass_cnt++;
            r.total = pass_cnt;
            r.last  = last;
            due_results.push_back(r);

            chars_seen++;
            if (r.passes) windows_passed++;
            if (last) begin
                strings_closed++;
                clear_string();
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic full, logic passes, logic [PASS_W-1:0] total, logic last);
            t_window_result want;
            results_checked++;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with no character pending",
                                 results_checked));
                return;
            end
            want = due_results.pop_front();
            if (full !== want.full)
                report($sformatf("result %0d: window_full %b, expected %b",
                                 results_checked, full, want.full));
            if (passes !== want.passes)
                report($sformatf("result %0d: window_passes %b, expected %b",
                                 results_checked, passes, want.passes));
            if (total !== want.total)
                report($sformatf("result %0d: pass_total %0d, expected %0d",
                                 results_checked, total, want.total));
            if (last !== want.last)
                report($sformatf("result %0d: final_result %b, expected %b",
                                 results_checked, last, want.last));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [CHAR_W-1:0]    i_char_byte;
    logic                 i_end_of_string;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_window_full;
    logic                 o_window_passes;
    logic [PASS_W-1:0]    o_pass_total;
    logic                 o_final_result;

    window_tally tally_chk = new();

    // Idling controls, set per phase by the stimulus
    bit               gaps_on;
    bit               stalls_on;
    bit               hold_request;
    int               holds_done;
    int               random_items;
    logic [CFG_W-1:0] len_setting = 1;   // last window length written

    window_base_count_filter_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_byte     (i_char_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_window_full   (o_window_full),
        .o_window_passes (o_window_passes),
        .o_pass_total    (o_pass_total),
        .o_final_result  (o_final_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Handshakes are judged on the values held just before the edge; all
    // drivers update with nonblocking writes, so this order is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tally_chk.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) tally_chk.take_char(i_char_byte, i_end_of_string);
            if (o_valid && i_ready)
                tally_chk.check_result(o_window_full, o_window_passes, o_pass_total,
                                       o_final_result);
        end
    end

    // Result side: random ready bursts, plus one long hold on request so
    // the internal queue fills and the input side backs up.
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end else if (stalls_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Mostly bases, some arbitrary bytes
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 19) < 3) return CHAR_W'($urandom_range(0, 255));
        return BASES[$urandom_range(0, NUM_LETTERS - 1)];
    endfunction

    // Leaves valid high; the caller or the next gap drops it.
    task automatic send_char(input logic [CHAR_W-1:0] b, input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_byte     <= b;
        i_end_of_string <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int k = 0; k < s.len(); k++) send_char(s[k], close && (k == s.len() - 1));
    endtask

    // Leaves cfg valid high; callers drop it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_WINDOW_LENGTH) len_setting = val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Every char yields a result, so an empty queue means the pipe is empty.
    // Waiting on the clock first lets the monitor log the char accepted at the
    // last edge; the trailing cycles after that are slack.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tally_chk.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int               phase;
        int               n;
        int unsigned      span;
        logic [CFG_W-1:0] v;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_char_byte     = '0;
        i_end_of_string = 1'b0;
        i_ready         = 1'b0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        hold_request    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // Reset settings: window of one, no minimums, so every char passes.
        send_char('0, 1'b0);
        send_char('1, 1'b0);
        send_char(ASCII_A, 1'b1);
        wait_idle();

        // Zero length acts as one; a T minimum above the window never passes;
        // write to the top (unused) index must change nothing.
        write_reg(REG_WINDOW_LENGTH, '0);
        write_reg(REG_MIN_T, CFG_W'(2));
        write_reg('1, '1);
        i_cfg_valid <= 1'b0;
        send_text("TT", 1'b1);
        wait_idle();

        // Window of 3 needing an A and a C: pass, fail, fail, pass, pass.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(3));
        write_reg(REG_MIN_A, CFG_W'(1));
        write_reg(REG_MIN_C, CFG_W'(1));
        write_reg(REG_MIN_T, '0);
        i_cfg_valid <= 1'b0;
        send_text("ACGTACG", 1'b1);
        wait_idle();

        // String ends before the window fills.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(5));
        i_cfg_valid <= 1'b0;
        send_text("ACG", 1'b1);
        wait_idle();

        // Oversized length clips to the ring depth; largest minimums.
        write_reg(REG_WINDOW_LENGTH, '1);
        write_reg(REG_MIN_A, '1);
        write_reg(REG_MIN_G, CFG_W'(WINDOW_MAX));
        i_cfg_valid <= 1'b0;
        send_text("aGT", 1'b1);
        wait_idle();

        // Open a string at exactly the ring depth, then shrink the window
        // mid-string: the restart means GGC gives not-full, fail, pass.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(WINDOW_MAX));
        write_reg(REG_MIN_A, '0);
        write_reg(REG_MIN_G, '0);
        i_cfg_valid <= 1'b0;
        send_text("CG", 1'b0);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, CFG_W'(2));
        i_cfg_valid <= 1'b0;
        send_text("GGC", 1'b1);

        // --- random phases ---
        for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
            wait_idle();
            if (random_items > RANDOM_ITEMS - QUIET_ITEMS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end

            if (phase == LONG_PHASE) begin
                // Long window run well past its fill; minimums near the
                // expected letter share so the pass result flips back and forth.
                write_reg(REG_WINDOW_LENGTH, CFG_W'(LONG_WINDOW));
                for (int r = REG_MIN_A; r <= REG_MIN_T; r++)
                    write_reg(CFG_IDX_W'(r), CFG_W'(LONG_WINDOW / 5));
                i_cfg_valid <= 1'b0;
                repeat (LONG_WINDOW + 40) begin
                    send_char(pick_char(), 1'b0);
                    random_items++;
                end
                send_char(pick_char(), 1'b1);
                random_items++;
            end else if (phase == HOLD_PHASE) begin
                write_reg(REG_WINDOW_LENGTH, CFG_W'(4));
                write_reg(REG_MIN_A, CFG_W'(1));
                write_reg(REG_MIN_C, '0);
                write_reg(REG_MIN_G, '0);
                write_reg(REG_MIN_T, '0);
                i_cfg_valid <= 1'b0;
                gaps_on      = 1'b0;
                hold_request = 1'b1;
                repeat (80) begin
                    send_char(pick_char(), $urandom_range(0, 15) == 0);
                    random_items++;
                end
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 19))
                        0:       v = '0;
                        1:       v = CFG_W'(WINDOW_MAX);
                        2:       v = CFG_W'($urandom_range(WINDOW_MAX + 1, 2**CFG_W - 1));
                        3, 4, 5: v = CFG_W'($urandom_range(9, 40));
                        default: v = CFG_W'($urandom_range(1, 8));
                    endcase
                    write_reg(REG_WINDOW_LENGTH, v);
                end
                span = (len_setting == '0) ? 1 :
                       (len_setting > WINDOW_MAX) ? WINDOW_MAX : len_setting;
                // small minimums so windows pass often; now and then any value
                for (int r = REG_MIN_A; r <= REG_MIN_T; r++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        if ($urandom_range(0, 9) == 0) v = CFG_W'($urandom);
                        else v = CFG_W'($urandom_range(0, (span + 3) / 4));
                        write_reg(CFG_IDX_W'(r), v);
                    end
                end
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 2**CFG_IDX_W - 1)),
                              CFG_W'($urandom));
                i_cfg_valid <= 1'b0;

                // Some phases stop mid-string; the next length write restarts it.
                n = $urandom_range(10, 40);
                for (int k = 0; k < n; k++) begin
                    send_char(pick_char(),
                              ($urandom_range(0, 15) == 0) ||
                              (k == n - 1 && $urandom_range(0, 1) == 0));
                    random_items++;
                end
            end
        end
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d chars in %0d closed strings over %0d phases, %0d reg writes.",
                 tally_chk.chars_seen, tally_chk.strings_closed, phase, tally_chk.reg_writes);
        $display("Checked %0d results, %0d passing windows, %0d long output hold(s).",
                 tally_chk.results_checked, tally_chk.windows_passed, holds_done);
        if (tally_chk.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: a few times the slowest legal run
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/wbcf_pkg.sv
rtl/core/wbcf_front.sv
rtl/core/wbcf_queue.sv
rtl/core/wbcf_back.sv
rtl/core/window_base_count_filter_unit.sv
tb/window_base_count_filter_unit_tb.sv
